FILE: design/kpl_pkg.sv
package kpl_pkg;

   // Build-time defaults for the top-level parameters.
   localparam int MAX_DIGITS_DEF = 6;
   localparam int MIN_DIGITS_DEF = 4;

   localparam int KEY_W      = 4;
   localparam int COUNT_W    = 3;
   localparam int FAIL_W     = 3;
   localparam int TICK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [FAIL_W-1:0] MAX_FAILURES_RST  = 3'd3;
   localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 8'd30;
   localparam logic [FAIL_W-1:0] FAIL_SAT          = 3'd7;

   // Key codes.
   localparam logic [KEY_W-1:0] KEY_ONE   = 4'd1;
   localparam logic [KEY_W-1:0] KEY_TWO   = 4'd2;
   localparam logic [KEY_W-1:0] KEY_NINE  = 4'd9;
   localparam logic [KEY_W-1:0] KEY_A     = 4'd10;
   localparam logic [KEY_W-1:0] KEY_STAR  = 4'd14;
   localparam logic [KEY_W-1:0] KEY_HASH  = 4'd15;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAILURES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_TICKS = 2'd1;

   typedef enum logic [2:0] {
      MODE_MENU    = 3'd0,
      MODE_ENTER   = 3'd1,
      MODE_LOCK    = 3'd2,
      MODE_OLD     = 3'd3,
      MODE_LENGTH  = 3'd4,
      MODE_NEW     = 3'd5,
      MODE_CONFIRM = 3'd6
   } mode_type;

   typedef enum logic [3:0] {
      EV_NONE       = 4'd0,
      EV_DIGIT      = 4'd1,
      EV_ERASE      = 4'd2,
      EV_PROMPT     = 4'd3,
      EV_SHORT      = 4'd4,
      EV_GRANTED    = 4'd5,
      EV_DENIED     = 4'd6,
      EV_LOCKSTART  = 4'd7,
      EV_LOCKEND    = 4'd8,
      EV_CHGDENIED  = 4'd9,
      EV_CHOOSELEN  = 4'd10,
      EV_LENSET     = 4'd11,
      EV_NEWTAKEN   = 4'd12,
      EV_SAVED      = 4'd13,
      EV_MISMATCH   = 4'd14,
      EV_TOMENU     = 4'd15
   } event_type;

   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic [3:0]         event_res;
      logic [2:0]         mode;
      logic [COUNT_W-1:0] typed_count;
      logic [FAIL_W-1:0]  fail_count;
      logic [TICK_W-1:0]  seconds_left;
      logic               alarm_led;
      logic               pin_present;
   } rsp_word_type;

   typedef struct packed {
      logic [FAIL_W-1:0] max_failures;
      logic [TICK_W-1:0] lockout_ticks;
   } cfg_type;

endpackage

FILE: design/kpl_csr.sv
module kpl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kpl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kpl_pkg::CSR_DATA_W-1:0]   csr_data,
   output kpl_pkg::cfg_type                 cfg
);

   logic [kpl_pkg::FAIL_W-1:0] max_failures_ff;
   logic [kpl_pkg::TICK_W-1:0] lockout_ticks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_failures_ff  <= kpl_pkg::MAX_FAILURES_RST;
         lockout_ticks_ff <= kpl_pkg::LOCKOUT_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kpl_pkg::CSR_MAX_FAILURES:  max_failures_ff  <= csr_data[kpl_pkg::FAIL_W-1:0];
            kpl_pkg::CSR_LOCKOUT_TICKS: lockout_ticks_ff <= csr_data[kpl_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.max_failures  = max_failures_ff;
   assign cfg.lockout_ticks = lockout_ticks_ff;

endmodule

FILE: design/kpl_engine.sv
module kpl_engine #(
   parameter int MAX_DIGITS = kpl_pkg::MAX_DIGITS_DEF,
   parameter int MIN_DIGITS = kpl_pkg::MIN_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  kpl_pkg::req_word_type step_word,
   input  kpl_pkg::cfg_type      cfg,
   output kpl_pkg::rsp_word_type step_rsp
);

   localparam int LEN_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIGITS);
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_DIGITS);
   localparam logic [kpl_pkg::KEY_W-1:0] MAX_KEY = kpl_pkg::KEY_W'(MAX_DIGITS);
   localparam logic [kpl_pkg::KEY_W-1:0] MIN_KEY = kpl_pkg::KEY_W'(MIN_DIGITS);

   kpl_pkg::mode_type mode_ff, mode_in;
   logic [kpl_pkg::KEY_W-1:0] typed_ff [MAX_DIGITS];
   logic [kpl_pkg::KEY_W-1:0] saved_ff [MAX_DIGITS];
   logic [kpl_pkg::KEY_W-1:0] fresh_ff [MAX_DIGITS];
   logic [LEN_W-1:0] typed_len_ff, typed_len_in;
   logic [LEN_W-1:0] saved_len_ff, saved_len_in;
   logic [LEN_W-1:0] fresh_len_ff, fresh_len_in;
   logic saved_valid_ff, saved_valid_in;
   logic [kpl_pkg::FAIL_W-1:0] failures_ff, failures_in;
   logic [kpl_pkg::TICK_W-1:0] countdown_ff, countdown_in;

   kpl_pkg::event_type ev;
   logic wr_typed, copy_fresh, copy_saved;

   logic [kpl_pkg::KEY_W-1:0] key;
   logic is_key, is_digit, is_star, is_hash, is_tick;
   logic [LEN_W-1:0] limit;
   logic room, typed_empty, long_enough, len_full, len_key_ok;
   logic match_saved, match_fresh, lock_hit, count_end;
   logic [kpl_pkg::FAIL_W-1:0] fail_inc;

   // Decode and compare; every digit slot is checked in parallel.
   always_comb begin
      key         = step_word.key;
      is_tick     = step_word.func;
      is_key      = !step_word.func;
      is_digit    = key <= kpl_pkg::KEY_NINE;
      is_star     = key == kpl_pkg::KEY_STAR;
      is_hash     = key == kpl_pkg::KEY_HASH;
      limit       = (mode_ff inside {kpl_pkg::MODE_NEW, kpl_pkg::MODE_CONFIRM})
                    ? fresh_len_ff : MAX_LEN;
      room        = typed_len_ff < limit;
      typed_empty = typed_len_ff == '0;
      long_enough = typed_len_ff >= MIN_LEN;
      len_full    = typed_len_ff == fresh_len_ff;
      len_key_ok  = is_digit && (key inside {[MIN_KEY:MAX_KEY]});
      fail_inc    = (failures_ff == kpl_pkg::FAIL_SAT) ? failures_ff
                    : failures_ff + kpl_pkg::FAIL_W'(1);
      lock_hit    = fail_inc >= cfg.max_failures;
      count_end   = countdown_ff <= kpl_pkg::TICK_W'(1);
      match_saved = saved_valid_ff && typed_len_ff == saved_len_ff;
      match_fresh = 1'b1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (LEN_W'(i) < typed_len_ff) begin
            if (typed_ff[i] != saved_ff[i]) match_saved = 1'b0;
            if (typed_ff[i] != fresh_ff[i]) match_fresh = 1'b0;
         end
      end
   end

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      if (is_tick) begin
         if (mode_ff == kpl_pkg::MODE_LOCK && count_end) mode_in = kpl_pkg::MODE_MENU;
      end else begin
         case (mode_ff)
            kpl_pkg::MODE_MENU: begin
               if (key == kpl_pkg::KEY_ONE) begin
                  mode_in = kpl_pkg::MODE_ENTER;
               end else if (key inside {kpl_pkg::KEY_TWO, kpl_pkg::KEY_A}) begin
                  mode_in = saved_valid_ff ? kpl_pkg::MODE_OLD : kpl_pkg::MODE_LENGTH;
               end
            end
            kpl_pkg::MODE_ENTER: begin
               if (is_hash && long_enough) begin
                  if (match_saved) mode_in = kpl_pkg::MODE_MENU;
                  else if (lock_hit) mode_in = kpl_pkg::MODE_LOCK;
               end
            end
            kpl_pkg::MODE_OLD: begin
               if (is_star && typed_empty) mode_in = kpl_pkg::MODE_MENU;
               else if (is_hash && !is_digit)
                  mode_in = match_saved ? kpl_pkg::MODE_LENGTH : kpl_pkg::MODE_MENU;
            end
            kpl_pkg::MODE_LENGTH: begin
               if (len_key_ok) mode_in = kpl_pkg::MODE_NEW;
               else if (is_star) mode_in = kpl_pkg::MODE_MENU;
            end
            kpl_pkg::MODE_NEW: begin
               if (is_star && typed_empty) mode_in = kpl_pkg::MODE_MENU;
               else if (is_hash && len_full) mode_in = kpl_pkg::MODE_CONFIRM;
            end
            kpl_pkg::MODE_CONFIRM: begin
               if (is_star && typed_empty) mode_in = kpl_pkg::MODE_MENU;
               else if (is_hash && len_full)
                  mode_in = match_fresh ? kpl_pkg::MODE_MENU : kpl_pkg::MODE_NEW;
            end
            default: ;
         endcase
      end
   end

   // Event and datapath updates.
   always_comb begin
      ev             = kpl_pkg::EV_NONE;
      typed_len_in   = typed_len_ff;
      saved_len_in   = saved_len_ff;
      fresh_len_in   = fresh_len_ff;
      saved_valid_in = saved_valid_ff;
      failures_in    = failures_ff;
      countdown_in   = countdown_ff;
      wr_typed       = 1'b0;
      copy_fresh     = 1'b0;
      copy_saved     = 1'b0;
      if (is_tick) begin
         if (mode_ff == kpl_pkg::MODE_LOCK) begin
            if (count_end) begin
               countdown_in = '0;
               typed_len_in = '0;
               ev           = kpl_pkg::EV_LOCKEND;
            end else begin
               countdown_in = countdown_ff - kpl_pkg::TICK_W'(1);
            end
         end
      end else begin
         case (mode_ff)
            kpl_pkg::MODE_MENU: begin
               if (key == kpl_pkg::KEY_ONE) begin
                  typed_len_in = '0;
                  ev           = kpl_pkg::EV_PROMPT;
               end else if (key inside {kpl_pkg::KEY_TWO, kpl_pkg::KEY_A}) begin
                  typed_len_in = '0;
                  ev = saved_valid_ff ? kpl_pkg::EV_PROMPT : kpl_pkg::EV_CHOOSELEN;
               end
            end
            kpl_pkg::MODE_ENTER: begin
               if (is_digit) begin
                  if (room) begin
                     wr_typed     = 1'b1;
                     typed_len_in = typed_len_ff + LEN_W'(1);
                     ev           = kpl_pkg::EV_DIGIT;
                  end
               end else if (is_star) begin
                  if (!typed_empty) begin
                     typed_len_in = typed_len_ff - LEN_W'(1);
                     ev           = kpl_pkg::EV_ERASE;
                  end
               end else if (is_hash) begin
                  typed_len_in = '0;
                  if (!long_enough) begin
                     ev = kpl_pkg::EV_SHORT;
                  end else if (match_saved) begin
                     failures_in = '0;
                     ev          = kpl_pkg::EV_GRANTED;
                  end else if (lock_hit) begin
                     failures_in  = '0;
                     countdown_in = cfg.lockout_ticks;
                     ev           = kpl_pkg::EV_LOCKSTART;
                  end else begin
                     failures_in = fail_inc;
                     ev          = kpl_pkg::EV_DENIED;
                  end
               end
            end
            kpl_pkg::MODE_LENGTH: begin
               if (len_key_ok) begin
                  fresh_len_in = LEN_W'(key);
                  typed_len_in = '0;
                  ev           = kpl_pkg::EV_LENSET;
               end else if (is_star) begin
                  typed_len_in = '0;
                  ev           = kpl_pkg::EV_TOMENU;
               end
            end
            kpl_pkg::MODE_OLD, kpl_pkg::MODE_NEW, kpl_pkg::MODE_CONFIRM: begin
               if (is_digit) begin
                  if (room) begin
                     wr_typed     = 1'b1;
                     typed_len_in = typed_len_ff + LEN_W'(1);
                     ev           = kpl_pkg::EV_DIGIT;
                  end
               end else if (is_star) begin
                  if (!typed_empty) begin
                     typed_len_in = typed_len_ff - LEN_W'(1);
                     ev           = kpl_pkg::EV_ERASE;
                  end else begin
                     ev = kpl_pkg::EV_TOMENU;
                  end
               end else if (is_hash) begin
                  if (mode_ff == kpl_pkg::MODE_OLD) begin
                     typed_len_in = '0;
                     ev = match_saved ? kpl_pkg::EV_CHOOSELEN : kpl_pkg::EV_CHGDENIED;
                  end else if (len_full) begin
                     typed_len_in = '0;
                     if (mode_ff == kpl_pkg::MODE_NEW) begin
                        copy_fresh = 1'b1;
                        ev         = kpl_pkg::EV_NEWTAKEN;
                     end else if (match_fresh) begin
                        copy_saved     = 1'b1;
                        saved_len_in   = fresh_len_ff;
                        saved_valid_in = 1'b1;
                        ev             = kpl_pkg::EV_SAVED;
                     end else begin
                        ev = kpl_pkg::EV_MISMATCH;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= kpl_pkg::MODE_MENU;
         typed_len_ff   <= '0;
         saved_len_ff   <= '0;
         fresh_len_ff   <= '0;
         saved_valid_ff <= 1'b0;
         failures_ff    <= '0;
         countdown_ff   <= '0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         typed_len_ff   <= typed_len_in;
         saved_len_ff   <= saved_len_in;
         fresh_len_ff   <= fresh_len_in;
         saved_valid_ff <= saved_valid_in;
         failures_ff    <= failures_in;
         countdown_ff   <= countdown_in;
      end
   end

   // Digit stores. Slots past the current length are never compared, so whole
   // stores are copied.
   always_ff @(posedge clock) begin
      if (step_en && is_key && wr_typed) typed_ff[typed_len_ff[IDX_W-1:0]] <= key;
      if (step_en && is_key && copy_fresh) fresh_ff <= typed_ff;
      if (step_en && is_key && copy_saved) saved_ff <= fresh_ff;
   end

   always_comb begin
      step_rsp.event_res    = ev;
      step_rsp.mode         = mode_in;
      step_rsp.typed_count  = kpl_pkg::COUNT_W'(typed_len_in);
      step_rsp.fail_count   = failures_in;
      step_rsp.seconds_left = (mode_in == kpl_pkg::MODE_LOCK) ? countdown_in : '0;
      step_rsp.alarm_led    = mode_in == kpl_pkg::MODE_LOCK;
      step_rsp.pin_present  = saved_valid_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      typed_len_ff <= MAX_LEN)
      else $error("typed length beyond digit capacity");

   a_lock_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == kpl_pkg::MODE_LOCK |-> typed_len_ff == '0)
      else $error("digits held during lockout");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != kpl_pkg::MODE_LOCK |-> countdown_ff == '0)
      else $error("countdown running outside lockout");

   a_lock_entry: assert property (@(posedge clock) disable iff (reset)
      step_en && ev == kpl_pkg::EV_LOCKSTART
      |=> mode_ff == kpl_pkg::MODE_LOCK && failures_ff == '0)
      else $error("lockout start did not lock or clear failures");

   a_fresh_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == kpl_pkg::MODE_NEW || mode_ff == kpl_pkg::MODE_CONFIRM)
      |-> fresh_len_ff >= MIN_LEN && fresh_len_ff <= MAX_LEN)
      else $error("new PIN length out of range");

endmodule

FILE: design/keypad_pin_lock_controller.sv
// Keypad PIN lock controller.
// The req channel carries one word per key press or one-second tick (func 0
// for a key, 1 for a tick). Every accepted word produces exactly one rsp word
// with the event, the mode after the step, the digit count, the failure count,
// the remaining lockout seconds, the alarm flag and whether a PIN is stored.
// The csr channel writes max_failures (index 0) and lockout_ticks (index 1);
// it is always ready and is meant to be written while no word is in flight.
// A word taken from req sits in the input register, is processed by the
// combinational engine and is loaded into the output register when it may
// advance, so rsp_valid rises once the result stands in that register.
// One word per cycle is accepted and
// delivered as long as rsp is not stalled; the rate is set by the single
// engine pass between the input and output registers.
// When rsp_stall is high the result holds in the output register and one more
// word may wait in the input register; after that req_stall rises.
// Reset is synchronous and returns the lock to the menu with no PIN stored,
// no failures counted and the configuration at 3 failures and 30 ticks.
module keypad_pin_lock_controller #(
   parameter int MAX_DIGITS = kpl_pkg::MAX_DIGITS_DEF,
   parameter int MIN_DIGITS = kpl_pkg::MIN_DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  kpl_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output kpl_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kpl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kpl_pkg::CSR_DATA_W-1:0]  csr_data
);

   kpl_pkg::cfg_type      cfg;
   kpl_pkg::req_word_type in_word_ff;
   kpl_pkg::rsp_word_type rsp_word_ff, step_rsp;
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance, req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_word_ff <= req_word;
      if (advance) rsp_word_ff <= step_rsp;
   end

   kpl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kpl_engine #(
      .MAX_DIGITS (MAX_DIGITS),
      .MIN_DIGITS (MIN_DIGITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_word (in_word_ff),
      .cfg       (cfg),
      .step_rsp  (step_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
